// ----- rtl/m3i_pkg.sv -----
`timescale 1ns / 1ps

package m3i_pkg;

    // Nine matrix elements in, nine inverse lanes out
    localparam int unsigned LANES = 9;
    // Elements of the first row used in the determinant expansion
    localparam int unsigned TERMS = 3;

    // Minor of element k is A[k][0]*A[k][3] - A[k][1]*A[k][2] over flat element indices
    localparam int unsigned MINOR_IDX [LANES][4] = '{
        '{4, 5, 7, 8},
        '{3, 5, 6, 8},
        '{3, 4, 6, 7},
        '{1, 2, 7, 8},
        '{0, 2, 6, 8},
        '{0, 1, 6, 7},
        '{1, 2, 4, 5},
        '{0, 2, 3, 5},
        '{0, 1, 3, 4}
    };

    // Cofactor sign: set where row plus column is odd
    localparam logic [LANES-1:0] COF_NEG = 9'b010101010;

    // Flags that ride alongside the divider lanes
    typedef struct packed {
        logic singular;
        logic det_ovf;
    } m3i_flags_t;

endpackage

// ----- rtl/m3i_front.sv -----
`timescale 1ns / 1ps

module m3i_front #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int XW = 132
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  a [m3i_pkg::LANES],
    output logic                 out_valid,
    output logic [XW-1:0]        num [m3i_pkg::LANES],
    output logic                 neg [m3i_pkg::LANES],
    output logic [XW-1:0]        den,
    output logic [W-1:0]         det_val,
    output m3i_pkg::m3i_flags_t  flags
);

    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int N  = m3i_pkg::LANES;
    localparam int T  = m3i_pkg::TERMS;

    logic [5:0] valid_reg;

    logic signed [W-1:0]  a1_reg   [N];
    logic signed [PW-1:0] p_reg    [2*N];
    logic signed [W-1:0]  a2_reg   [T];
    logic signed [CW-1:0] cof3_reg [N];
    logic signed [W-1:0]  a3_reg   [T];
    logic signed [CW-1:0] cof4_reg [N];
    logic signed [CW-1:0] plo_reg  [T];
    logic signed [CW-1:0] phi_reg  [T];
    logic signed [CW-1:0] cof5_reg [N];
    logic signed [DW-1:0] det_reg;

    logic signed [CW-1:0] cof_next [N];
    logic signed [DW-1:0] det_next;
    logic [XW-1:0]        num_next [N];
    logic                 neg_next [N];
    logic [XW-1:0]        num_reg  [N];
    logic                 neg_reg  [N];
    logic [XW-1:0]        den_reg;
    logic [W-1:0]         detv_reg;
    m3i_pkg::m3i_flags_t  flags_reg;

    logic                 dneg;
    logic [DW-1:0]        dmag;
    logic [DW:0]          rsum;
    logic [DW:0]          rq;
    logic [DW:0]          dlim;
    logic [DW:0]          dm;
    logic                 dsat;

    // Advance the valid marks through the six stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    // Form cofactors from the paired products
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            if (m3i_pkg::COF_NEG[k])
            begin
                cof_next[k] = CW'(p_reg[2*k+1]) - CW'(p_reg[2*k]);
            end
            else
            begin
                cof_next[k] = CW'(p_reg[2*k]) - CW'(p_reg[2*k+1]);
            end
        end
    end

    // Sum the first-row terms from their partial products
    always_comb
    begin
        det_next = '0;
        for (int i = 0; i < T; i++)
        begin
            det_next = det_next + (DW'(phi_reg[i]) <<< W) + DW'(plo_reg[i]);
        end
    end

    // Take magnitude, round the determinant and build divider operands
    always_comb
    begin
        dneg = det_reg[DW-1];
        dmag = dneg ? DW'(-det_reg) : DW'(det_reg);
        rsum = {1'b0, dmag} + ((DW+1)'(1) << (2*F-1));
        rq   = rsum >> (2*F);
        dlim = ((DW+1)'(1) << (W-1)) - (dneg ? (DW+1)'(0) : (DW+1)'(1));
        dsat = rq > dlim;
        dm   = dsat ? dlim : rq;
        for (int o = 0; o < N; o++)
        begin
            logic signed [CW-1:0] c;
            logic [CW-1:0]        cm;
            c  = cof5_reg[3*(o%3) + o/3];
            cm = c[CW-1] ? CW'(-c) : CW'(c);
            num_next[o] = (XW'(cm) << (2*F+1)) + XW'(dmag);
            neg_next[o] = c[CW-1] ^ dneg;
        end
    end

    // Hold the pipeline payload
    always_ff @(posedge clk)
    begin
        a1_reg <= a;
        for (int k = 0; k < N; k++)
        begin
            p_reg[2*k]   <= a1_reg[m3i_pkg::MINOR_IDX[k][0]] *
                            a1_reg[m3i_pkg::MINOR_IDX[k][3]];
            p_reg[2*k+1] <= a1_reg[m3i_pkg::MINOR_IDX[k][1]] *
                            a1_reg[m3i_pkg::MINOR_IDX[k][2]];
        end
        for (int i = 0; i < T; i++)
        begin
            a2_reg[i] <= a1_reg[i];
            a3_reg[i] <= a2_reg[i];
            plo_reg[i] <= a3_reg[i] * $signed({1'b0, cof3_reg[i][W-1:0]});
            phi_reg[i] <= a3_reg[i] * $signed(cof3_reg[i][CW-1:W]);
        end
        cof3_reg <= cof_next;
        cof4_reg <= cof3_reg;
        cof5_reg <= cof4_reg;
        det_reg  <= det_next;
        num_reg  <= num_next;
        neg_reg  <= neg_next;
        den_reg  <= XW'(dmag) << 1;
        detv_reg <= dneg ? W'(-dm) : W'(dm);
        flags_reg.singular <= (det_reg == '0);
        flags_reg.det_ovf  <= dsat;
    end

    assign out_valid = valid_reg[5];
    assign num       = num_reg;
    assign neg       = neg_reg;
    assign den       = den_reg;
    assign det_val   = detv_reg;
    assign flags     = flags_reg;

endmodule

// ----- rtl/m3i_div.sv -----
`timescale 1ns / 1ps

module m3i_div #(
    parameter int W  = 32,
    parameter int XW = 132
) (
    input  logic          clk,
    input  logic [XW-1:0] num,
    input  logic [XW-1:0] den,
    input  logic          neg,
    output logic [W-1:0]  quo,
    output logic          big,
    output logic          sign
);

    logic [XW-1:0] rem_reg [W+1];
    logic [XW-1:0] den_reg [W+1];
    logic [W-1:0]  q_reg   [W+1];
    logic          big_reg [W+1];
    logic          neg_reg [W+1];

    // Load the operands and flag quotients that cannot fit in W bits
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        big_reg[0] <= num >= (den << W);
        neg_reg[0] <= neg;
    end

    // Retire one quotient bit per stage, most significant first
    for (genvar s = 1; s <= W; s++)
    begin : g_step
        localparam int B = W - s;
        logic [XW-1:0] trial;
        logic          fit;

        assign trial = den_reg[s-1] << B;
        assign fit   = rem_reg[s-1] >= trial;

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= fit ? rem_reg[s-1] - trial : rem_reg[s-1];
            q_reg[s]   <= q_reg[s-1] | (fit ? (W'(1) << B) : W'(0));
            den_reg[s] <= den_reg[s-1];
            big_reg[s] <= big_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
        end
    end

    assign quo  = q_reg[W];
    assign big  = big_reg[W];
    assign sign = neg_reg[W];

endmodule

// ----- rtl/m3i_merge.sv -----
`timescale 1ns / 1ps

module m3i_merge #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [W-1:0]        quo  [m3i_pkg::LANES],
    input  logic                big  [m3i_pkg::LANES],
    input  logic                sign [m3i_pkg::LANES],
    input  logic [W-1:0]        det_val,
    input  m3i_pkg::m3i_flags_t flags,
    output logic                out_valid,
    output logic [W-1:0]        inv  [m3i_pkg::LANES],
    output logic [W-1:0]        det_out,
    output logic                singular,
    output logic                overflow
);

    localparam int N = m3i_pkg::LANES;

    logic         valid_reg;
    logic [W-1:0] inv_reg [N];
    logic [W-1:0] det_reg;
    logic         sing_reg;
    logic         ovf_reg;

    logic [W-1:0] inv_next [N];
    logic         ovf_next;

    // Saturate each lane and gather the overflow marks
    always_comb
    begin
        ovf_next = flags.det_ovf;
        for (int o = 0; o < N; o++)
        begin
            logic [W:0] lim;
            logic [W:0] m;
            logic       sat;
            lim = ((W+1)'(1) << (W-1)) - (sign[o] ? (W+1)'(0) : (W+1)'(1));
            sat = big[o] || ({1'b0, quo[o]} > lim);
            m   = sat ? lim : {1'b0, quo[o]};
            inv_next[o] = sign[o] ? W'(-m) : W'(m);
            ovf_next    = ovf_next | sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold the result; zero the inverse, determinant and overflow for a singular matrix
    always_ff @(posedge clk)
    begin
        for (int o = 0; o < N; o++)
        begin
            inv_reg[o] <= flags.singular ? '0 : inv_next[o];
        end
        det_reg  <= flags.singular ? '0 : det_val;
        sing_reg <= flags.singular;
        ovf_reg  <= flags.singular ? 1'b0 : ovf_next;
    end

    assign out_valid = valid_reg;
    assign inv       = inv_reg;
    assign det_out   = det_reg;
    assign singular  = sing_reg;
    assign overflow  = ovf_reg;

endmodule

// ----- rtl/matrix3_inverse.sv -----
`timescale 1ns / 1ps

// Channel   Ports                               Transfer
// command   start, busy, a00..a22               start high while busy low
// result    done, inv00..inv22, determinant,    done high for one cycle
//           singular, overflow
//
// One matrix is taken every cycle; busy is always low.
// done rises after six front stages, DATA_WIDTH + 1 divider stages and one merge
// stage, with the divider lanes retiring one quotient bit per stage.
// Reset clears only the valid marks; results in flight are dropped.
// The receiver cannot stall: each result is shown on done for one cycle.

module matrix3_inverse #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] a00,
    input  logic signed [DATA_WIDTH-1:0] a01,
    input  logic signed [DATA_WIDTH-1:0] a02,
    input  logic signed [DATA_WIDTH-1:0] a10,
    input  logic signed [DATA_WIDTH-1:0] a11,
    input  logic signed [DATA_WIDTH-1:0] a12,
    input  logic signed [DATA_WIDTH-1:0] a20,
    input  logic signed [DATA_WIDTH-1:0] a21,
    input  logic signed [DATA_WIDTH-1:0] a22,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] inv00,
    output logic signed [DATA_WIDTH-1:0] inv01,
    output logic signed [DATA_WIDTH-1:0] inv02,
    output logic signed [DATA_WIDTH-1:0] inv10,
    output logic signed [DATA_WIDTH-1:0] inv11,
    output logic signed [DATA_WIDTH-1:0] inv12,
    output logic signed [DATA_WIDTH-1:0] inv20,
    output logic signed [DATA_WIDTH-1:0] inv21,
    output logic signed [DATA_WIDTH-1:0] inv22,
    output logic signed [DATA_WIDTH-1:0] determinant,
    output logic                         singular,
    output logic                         overflow
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int N   = m3i_pkg::LANES;
    localparam int NW  = (((2*W + 2*F + 2) > (3*W + 4)) ? (2*W + 2*F + 2) : (3*W + 4)) + 1;
    localparam int XW  = (NW > (4*W + 4)) ? NW : (4*W + 4);
    localparam int LAT = W + 1;

    logic signed [W-1:0] a [N];
    logic                fr_valid;
    logic [XW-1:0]       num [N];
    logic                neg [N];
    logic [XW-1:0]       den;
    logic [W-1:0]        det_val;
    m3i_pkg::m3i_flags_t flags;

    logic [W-1:0]        quo  [N];
    logic                big  [N];
    logic                sign [N];

    logic [LAT-1:0]      valid_reg;
    logic [W-1:0]        detd_reg  [LAT];
    m3i_pkg::m3i_flags_t flagd_reg [LAT];

    logic [W-1:0]        inv [N];
    logic [W-1:0]        det_out;

    assign busy = 1'b0;

    assign a = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

    m3i_front #(
        .W  (W),
        .F  (F),
        .XW (XW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .a         (a),
        .out_valid (fr_valid),
        .num       (num),
        .neg       (neg),
        .den       (den),
        .det_val   (det_val),
        .flags     (flags)
    );

    // One divider lane per inverse element
    for (genvar o = 0; o < N; o++)
    begin : g_lane
        m3i_div #(
            .W  (W),
            .XW (XW)
        ) u_div (
            .clk  (clk),
            .num  (num[o]),
            .den  (den),
            .neg  (neg[o]),
            .quo  (quo[o]),
            .big  (big[o]),
            .sign (sign[o])
        );
    end

    // Advance valid marks alongside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], fr_valid};
        end
    end

    // Hold determinant and flags until the lanes finish
    always_ff @(posedge clk)
    begin
        detd_reg[0]  <= det_val;
        flagd_reg[0] <= flags;
        for (int s = 1; s < LAT; s++)
        begin
            detd_reg[s]  <= detd_reg[s-1];
            flagd_reg[s] <= flagd_reg[s-1];
        end
    end

    m3i_merge #(
        .W (W)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_reg[LAT-1]),
        .quo       (quo),
        .big       (big),
        .sign      (sign),
        .det_val   (detd_reg[LAT-1]),
        .flags     (flagd_reg[LAT-1]),
        .out_valid (done),
        .inv       (inv),
        .det_out   (det_out),
        .singular  (singular),
        .overflow  (overflow)
    );

    assign inv00       = inv[0];
    assign inv01       = inv[1];
    assign inv02       = inv[2];
    assign inv10       = inv[3];
    assign inv11       = inv[4];
    assign inv12       = inv[5];
    assign inv20       = inv[6];
    assign inv21       = inv[7];
    assign inv22       = inv[8];
    assign determinant = det_out;

endmodule
